[hw/rtl/urb_pkg.sv]
// shared types, register codes, bit positions and trigger tables of the uart register block
package urb_pkg;

	localparam int FIFO_DEPTH_DEF = 16;

	// item kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_BREAK = 2'd3;

	// register indexes
	localparam logic [3:0] REG_MODE    = 4'd0;
	localparam logic [3:0] REG_BITRATE = 4'd1;
	localparam logic [3:0] REG_CONTROL = 4'd2;
	localparam logic [3:0] REG_TXDATA  = 4'd3;
	localparam logic [3:0] REG_STATUS  = 4'd4;
	localparam logic [3:0] REG_RXDATA  = 4'd5;
	localparam logic [3:0] REG_FIFOCTL = 4'd6;
	localparam logic [3:0] REG_COUNT   = 4'd7;
	localparam logic [3:0] REG_PORT    = 4'd8;
	localparam logic [3:0] REG_LINE    = 4'd9;

	// status bit positions
	localparam int ST_ER   = 7;
	localparam int ST_TEND = 6;
	localparam int ST_TDFE = 5;
	localparam int ST_BRK  = 4;
	localparam int ST_FER  = 3;
	localparam int ST_PER  = 2;
	localparam int ST_RDF  = 1;
	localparam int ST_DR   = 0;

	// control bit positions
	localparam int CTL_TIE  = 7;
	localparam int CTL_RIE  = 6;
	localparam int CTL_TE   = 5;
	localparam int CTL_RE   = 4;
	localparam int CTL_REIE = 3;

	// fifo control bit positions
	localparam int FCR_TFRST = 2;
	localparam int FCR_RFRST = 1;

	localparam int MODE_CHR   = 6;
	localparam int PORT_IO    = 1;
	localparam int PORT_DT    = 0;

	// write masks and reset values
	localparam logic [7:0] MODE_MASK       = 8'h7B;
	localparam logic [7:0] CTRL_MASK       = 8'hFA;
	localparam logic [7:0] PORT_MASK       = 8'hF3;
	localparam logic [7:0] PORT_RD_CLR     = 8'h10;
	localparam logic [7:0] STATUS_CLR_MASK = 8'hF3;
	localparam logic [7:0] STATUS_RESET    = 8'h60;
	localparam logic [7:0] BITRATE_RESET   = 8'hFF;
	localparam logic [7:0] CHR_DATA_MASK   = 8'h7F;

	localparam logic [7:0] RX_LEVELS [4] = '{8'd1, 8'd4, 8'd8, 8'd14};
	localparam logic [7:0] TX_LEVELS [4] = '{8'd8, 8'd4, 8'd2, 8'd1};

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  reg_index;
		logic [15:0] write_value;
		logic        rx_present;
		logic [7:0]  rx_value;
	} req_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic        tx_strobe;
		logic [7:0]  tx_value;
		logic        irq_transmit;
		logic        irq_receive;
		logic        irq_break;
		logic        irq_error;
		logic        break_level;
	} rsp_t;

	// one fifo operation per item
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic [7:0] data;
	} fifo_op_t;

	// receive fifo reached its trigger level
	function automatic logic rx_full(input logic [7:0] cnt, input logic [1:0] rtrg);
		return cnt >= RX_LEVELS[rtrg];
	endfunction

	// transmit fifo at or below its trigger level
	function automatic logic tx_low(input logic [7:0] cnt, input logic [1:0] ttrg);
		return cnt <= TX_LEVELS[ttrg];
	endfunction

endpackage

[hw/rtl/fifo_uart_register_block_top.sv]
// top level of the uart register block with 16-byte transmit and receive fifos
//
// Items arrive on the req channel (req_valid / req_ready, payload req) and
// are bus reads, bus writes, frame ticks or received breaks. Each item gives
// exactly one result on the rsp channel (rsp_valid / rsp_ready, payload rsp):
// read data, the byte sent to the line, the four interrupt lines and the
// break level, all taken after the item's update.
// An accepted item sits in the input register, where the register
// and fifo update runs in one combinational pass, and lands in the output
// register, whose valid flag drives rsp_valid; one item
// is taken every cycle as long as results are taken.
// When the receiver stalls, the result waits in the output register and the
// input register holds one more item; req_ready then drops until rsp_ready.
// Reset empties both fifos, clears the control registers, sets status to
// TEND and TDFE and the bit rate register to all ones; no clearing pass is
// needed, so the block is ready right after reset.
module fifo_uart_register_block_top #(
	parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  urb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output urb_pkg::rsp_t rsp
);
	import urb_pkg::*;

	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t result;
	logic fire;

	// item in s1 moves on when the output register is free or being taken
	assign fire      = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || fire;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	urb_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
		.clk(clk), .arst_n(arst_n), .fire(fire), .item(item_s1), .result(result)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (fire) begin
			rsp_s2 <= result;
		end
	end

endmodule

[hw/rtl/urb_fifo.sv]
// byte fifo with head pointer, fill count and synchronous clear
module urb_fifo #(
	parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  urb_pkg::fifo_op_t              op,
	output logic [$clog2(FIFO_DEPTH+1)-1:0] count,
	output logic [7:0]                     head_data
);
	import urb_pkg::*;

	localparam int ADDR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

	logic [7:0]        store_q [FIFO_DEPTH];
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] wr_idx;

	// tail slot wraps with the pointer width
	assign wr_idx    = head_q + count_q[ADDR_W-1:0];
	assign head_data = store_q[head_q];
	assign count     = count_q;

	// data store, no reset
	always_ff @(posedge clk) begin
		if (op.push) begin
			store_q[wr_idx] <= op.data;
		end
	end

	// pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (op.clr) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (op.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (op.pop) begin
			head_q  <= head_q + ADDR_W'(1);
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

[hw/rtl/urb_core.sv]
// register file, status flags and per-item update logic of the uart block
module urb_core #(
	parameter int FIFO_DEPTH = urb_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  urb_pkg::req_t item,
	output urb_pkg::rsp_t result
);
	import urb_pkg::*;

	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [7:0] mode_q, bitrate_q, control_q, fifoctl_q, port_q, stat_q, seen_q;
	logic       sending_q, ovr_q;
	logic [7:0] mode_d, bitrate_d, control_d, fifoctl_d, port_d, stat_d, seen_d;
	logic       sending_d, ovr_d;
	logic [7:0] stat_n, seen_n, raise, smask, txd;
	logic [15:0] rd;
	logic        strobe;
	logic [7:0]  txv;

	fifo_op_t tx_op, rx_op, tx_op_g, rx_op_g;
	logic [CNT_W-1:0] tx_cnt, rx_cnt;
	logic [7:0]       tx_head_data, rx_head_data;

	urb_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_tx_fifo (
		.clk(clk), .arst_n(arst_n), .op(tx_op_g), .count(tx_cnt), .head_data(tx_head_data)
	);

	urb_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_rx_fifo (
		.clk(clk), .arst_n(arst_n), .op(rx_op_g), .count(rx_cnt), .head_data(rx_head_data)
	);

	// fifo operations only when an item is processed
	assign tx_op_g = fire ? tx_op : '0;
	assign rx_op_g = fire ? rx_op : '0;

	// next state for the item in hand
	always_comb begin
		mode_d    = mode_q;
		bitrate_d = bitrate_q;
		control_d = control_q;
		fifoctl_d = fifoctl_q;
		port_d    = port_q;
		stat_d    = stat_q;
		seen_d    = seen_q;
		sending_d = sending_q;
		ovr_d     = ovr_q;
		raise     = '0;
		smask     = '0;
		txd       = '0;
		rd        = '0;
		strobe    = 1'b0;
		txv       = '0;
		tx_op     = '0;
		rx_op     = '0;
		unique case (item.kind)
			KIND_READ: begin
				unique case (item.reg_index)
					REG_MODE:    rd = {8'h00, mode_q};
					REG_BITRATE: rd = {8'h00, bitrate_q};
					REG_CONTROL: rd = {8'h00, control_q};
					REG_STATUS: begin
						seen_d = stat_q;
						rd     = {8'h00, stat_q};
					end
					REG_RXDATA: begin
						if (rx_cnt != '0) begin
							rd        = {8'h00, rx_head_data};
							rx_op.pop = 1'b1;
						end
					end
					REG_FIFOCTL: rd = {8'h00, fifoctl_q};
					REG_COUNT:   rd = {8'(tx_cnt), 8'(rx_cnt)};
					REG_PORT:    rd = {8'h00, port_q & ~PORT_RD_CLR};
					REG_LINE:    rd = {15'h0000, ovr_q};
					default:     rd = '0;
				endcase
			end
			KIND_WRITE: begin
				unique case (item.reg_index)
					REG_MODE:    mode_d = item.write_value[7:0] & MODE_MASK;
					REG_BITRATE: bitrate_d = item.write_value[7:0];
					REG_CONTROL: begin
						control_d = item.write_value[7:0] & CTRL_MASK;
						if (!control_d[CTL_TE]) begin
							raise[ST_TEND] = 1'b1;
						end
					end
					REG_TXDATA: begin
						txd = item.write_value[7:0];
						if (mode_q[MODE_CHR]) begin
							txd = txd & CHR_DATA_MASK;
						end
						// dropped while the transmit fifo is held in reset
						if (!fifoctl_q[FCR_TFRST]) begin
							if (tx_cnt == '0 && !sending_q && control_q[CTL_TE]) begin
								strobe         = 1'b1;
								txv            = txd;
								sending_d      = 1'b1;
								raise[ST_TDFE] = 1'b1;
							end else if (32'(tx_cnt) < FIFO_DEPTH) begin
								tx_op.push = 1'b1;
								tx_op.data = txd;
							end
						end
					end
					REG_STATUS: begin
						// clear only flags seen as set, keep those whose condition holds
						smask = item.write_value[7:0] | ~STATUS_CLR_MASK | ~seen_q;
						if (rx_full(8'(rx_cnt), fifoctl_q[7:6])) begin
							smask[ST_RDF] = 1'b1;
						end
						if (tx_low(8'(tx_cnt), fifoctl_q[5:4])) begin
							smask[ST_TDFE] = 1'b1;
						end
						stat_d = stat_q & smask;
						seen_d = seen_q & smask;
					end
					REG_FIFOCTL: begin
						if (fifoctl_q[FCR_TFRST] && !item.write_value[FCR_TFRST]) begin
							raise[ST_TEND] = 1'b1;
							raise[ST_TDFE] = 1'b1;
						end
						fifoctl_d = item.write_value[7:0];
						if (item.write_value[FCR_TFRST]) begin
							tx_op.clr = 1'b1;
							sending_d = 1'b0;
						end
						if (item.write_value[FCR_RFRST]) begin
							rx_op.clr = 1'b1;
						end
					end
					REG_PORT: port_d = item.write_value[7:0] & PORT_MASK;
					REG_LINE: ovr_d = item.write_value[0];
					default: begin
					end
				endcase
			end
			KIND_TICK: begin
				// transmitter
				if (sending_q && !fifoctl_q[FCR_TFRST]) begin
					if (tx_cnt == '0) begin
						raise[ST_TEND] = 1'b1;
						sending_d      = 1'b0;
					end else begin
						strobe    = 1'b1;
						txv       = tx_head_data;
						tx_op.pop = 1'b1;
						if (tx_low(8'(tx_cnt - CNT_W'(1)), fifoctl_q[5:4])) begin
							raise[ST_TDFE] = 1'b1;
						end
					end
				end
				// receiver
				if (item.rx_present) begin
					if (control_q[CTL_RE] && !fifoctl_q[FCR_RFRST]) begin
						if (32'(rx_cnt) >= FIFO_DEPTH) begin
							ovr_d = 1'b1;
						end else begin
							rx_op.push = 1'b1;
							rx_op.data = item.rx_value;
							if (rx_full(8'(rx_cnt + CNT_W'(1)), fifoctl_q[7:6])) begin
								raise[ST_RDF] = 1'b1;
							end
						end
					end
				end else if (rx_cnt != '0) begin
					raise[ST_DR] = 1'b1;
				end
			end
			KIND_BREAK: raise[ST_BRK] = 1'b1;
		endcase
		// a raised flag counts as not yet seen
		stat_n = stat_d | raise;
		seen_n = seen_d & ~raise;
	end

	// result fields from the updated state
	always_comb begin
		result.read_value   = rd;
		result.tx_strobe    = strobe;
		result.tx_value     = txv;
		result.irq_transmit = stat_n[ST_TDFE] & control_d[CTL_TIE];
		result.irq_receive  = (stat_n[ST_RDF] | stat_n[ST_DR]) & control_d[CTL_RIE];
		result.irq_break    = stat_n[ST_BRK] & (control_d[CTL_RIE] | control_d[CTL_REIE]);
		result.irq_error    = (stat_n[ST_ER] | stat_n[ST_FER] | stat_n[ST_PER])
			& (control_d[CTL_RIE] | control_d[CTL_REIE]);
		result.break_level  = port_d[PORT_IO] & ~port_d[PORT_DT] & ~control_d[CTL_TE];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			bitrate_q <= BITRATE_RESET;
			control_q <= '0;
			fifoctl_q <= '0;
			port_q    <= '0;
			stat_q    <= STATUS_RESET;
			seen_q    <= '0;
			sending_q <= 1'b0;
			ovr_q     <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			bitrate_q <= bitrate_d;
			control_q <= control_d;
			fifoctl_q <= fifoctl_d;
			port_q    <= port_d;
			stat_q    <= stat_n;
			seen_q    <= seen_n;
			sending_q <= sending_d;
			ovr_q     <= ovr_d;
		end
	end

endmodule
